>>> hw/rtl/sort_engine_asc_desc_assert.svh
// ----------------------------------------------------------------------------
// sort engine assertion macros
// shared property wrappers for the sort engine checker
// ----------------------------------------------------------------------------
`ifndef SORT_ENGINE_ASC_DESC_ASSERT_SVH
`define SORT_ENGINE_ASC_DESC_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SEA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define SEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sea_pkg.sv
// ----------------------------------------------------------------------------
// sea_pkg
// request types shared by the sort engine modules
// ----------------------------------------------------------------------------
`default_nettype none

package sea_pkg;

  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } in_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    descending;
    logic                    end_of_run;
    logic                    overflowed;
  } out_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/sea_stream_if.sv
// ----------------------------------------------------------------------------
// sea_stream_if
// valid/ready channel carrying one request per handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface sea_stream_if #(
  parameter type data_t = logic
);

  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

>>> hw/rtl/sea_out_reg.sv
// ----------------------------------------------------------------------------
// sea_out_reg
// output register stage, holds one result request until taken
// ----------------------------------------------------------------------------
`default_nettype none

module sea_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire sea_pkg::out_req_t data_i,
  input  wire logic              ready_i,
  output logic                   valid_o,
  output sea_pkg::out_req_t      data_o,
  output logic                   free_o
);

  logic              valid_q, valid_d;
  sea_pkg::out_req_t data_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> hw/rtl/sea_sorter.sv
// ----------------------------------------------------------------------------
// sea_sorter
// element store, shared compare-and-swap unit and its sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module sea_sorter #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire sea_pkg::in_req_t  in_data_i,
  output logic                   in_ready_o,
  input  wire logic              out_free_i,
  output logic                   out_load_o,
  output sea_pkg::out_req_t      out_data_o
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned KW = CW + 1;
  localparam int unsigned DW = sea_pkg::DataW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_WB    = 7'b0010000,
    S_ORD   = 7'b0100000,
    S_OPUT  = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [AW-1:0]        i_q, i_d;
  logic [AW-1:0]        j_q, j_d;
  logic [KW-1:0]        k_q, k_d;
  logic signed [DW-1:0] a_q, a_d;
  logic signed [DW-1:0] rd_q;
  logic signed [DW-1:0] mem [MAX_ITEMS];

  logic                 we;
  logic [AW-1:0]        wa;
  logic signed [DW-1:0] wd;
  logic                 rd_en;
  logic [AW-1:0]        ra;

  logic                 in_acc;
  logic [CW-1:0]        n_new;
  logic [KW-1:0]        kn;
  logic [KW-1:0]        k_last;
  logic [KW-1:0]        k_nxt;

  // position in store for result index k: ascending then mirrored
  function automatic logic [AW-1:0] out_addr(input logic [KW-1:0] k,
                                             input logic [KW-1:0] n);
    logic [KW-1:0] rev;
    rev = (n << 1) - k - KW'(1);
    if (k < n) begin
      out_addr = k[AW-1:0];
    end else begin
      out_addr = rev[AW-1:0];
    end
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign kn         = KW'(cnt_q);
  assign k_last     = (kn << 1) - KW'(1);
  assign k_nxt      = k_q + KW'(1);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    a_d        = a_q;
    we         = 1'b0;
    wa         = '0;
    wd         = a_q;
    rd_en      = 1'b0;
    ra         = '0;
    out_load_o = 1'b0;
    n_new      = cnt_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_q < CW'(MAX_ITEMS)) begin
            we    = 1'b1;
            wa    = cnt_q[AW-1:0];
            wd    = in_data_i.value;
            n_new = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          cnt_d = n_new;
          if (in_data_i.last) begin
            i_d = '0;
            k_d = '0;
            if (n_new >= CW'(2)) begin
              state_d = S_FETCH;
            end else begin
              state_d = S_ORD;
            end
          end
        end
      end
      S_FETCH: begin
        rd_en   = 1'b1;
        ra      = i_q;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        a_d     = rd_q;
        j_d     = i_q + AW'(1);
        rd_en   = 1'b1;
        ra      = i_q + AW'(1);
        state_d = S_CMP;
      end
      S_CMP: begin
        if (a_q > rd_q) begin
          we  = 1'b1;
          wa  = j_q;
          wd  = a_q;
          a_d = rd_q;
        end
        if (CW'(j_q) == cnt_q - CW'(1)) begin
          state_d = S_WB;
        end else begin
          j_d   = j_q + AW'(1);
          rd_en = 1'b1;
          ra    = j_q + AW'(1);
        end
      end
      S_WB: begin
        we = 1'b1;
        wa = i_q;
        wd = a_q;
        if (CW'(i_q) + CW'(2) == cnt_q) begin
          k_d     = '0;
          state_d = S_ORD;
        end else begin
          i_d     = i_q + AW'(1);
          state_d = S_FETCH;
        end
      end
      S_ORD: begin
        rd_en   = 1'b1;
        ra      = out_addr(k_q, kn);
        state_d = S_OPUT;
      end
      S_OPUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          if (k_q == k_last) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            k_d   = k_nxt;
            rd_en = 1'b1;
            ra    = out_addr(k_nxt, kn);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_data_o.sorted_value = rd_q;
  assign out_data_o.descending   = (k_q >= kn);
  assign out_data_o.end_of_run   = (k_q == k_last);
  assign out_data_o.overflowed   = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
  end

  // element store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_q <= mem[ra];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sort_engine_asc_desc.sv
// ----------------------------------------------------------------------------
// sort_engine_asc_desc
// exchange sort of a set of signed words, emitted ascending then descending
//
// req_i takes one element per request, one per cycle while loading; the
// request with last set closes the set and is part of it. Elements past
// MAX_ITEMS are dropped and flagged as overflowed on every result of the set.
// After the closing request req_i.ready stays low while the set is sorted
// and emitted. The sort uses one compare-and-swap unit on a one-write,
// one-read store: each pass fetches an element, compares it with every later
// one, swapping as it goes, and writes the smallest back to the pass's slot.
// res_o then gives 2n results at one per cycle: ascending run, then the
// descending run with end_of_run on its final result. A stalled res_o holds
// its result and pauses the run; loading of the next set resumes once the
// final result sits in the output register.
// Reset empties the set and clears the overflow flag and res_o.valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sort_engine_asc_desc #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sea_stream_if.sink  req_i,
  sea_stream_if.source res_o
);

  logic              out_free;
  logic              out_load;
  sea_pkg::out_req_t out_data;
  sea_pkg::in_req_t  in_data;

  assign in_data = req_i.data;

  sea_sorter #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_sorter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_data_i  (in_data),
    .in_ready_o (req_i.ready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .out_data_o (out_data)
  );

  sea_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .data_i  (out_data),
    .ready_i (res_o.ready),
    .valid_o (res_o.valid),
    .data_o  (res_o.data),
    .free_o  (out_free)
  );

endmodule

`default_nettype wire

>>> hw/rtl/sea_checker.sv
// ----------------------------------------------------------------------------
// sea_checker
// port-level checks for the sort engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sort_engine_asc_desc_assert.svh"

module sea_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_last_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_desc_i,
  input wire logic out_end_i
);

  `SEA_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")
  `SEA_ASSERT_IMPL(a_end_desc, out_valid_i && out_end_i, out_desc_i, "end of run not descending")
  `SEA_ASSERT_NEXT(a_busy_last, in_valid_i && in_ready_i && in_last_i, !in_ready_i, "still ready")

endmodule

bind sort_engine_asc_desc sea_checker u_sea_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_last_i   (req_i.data.last),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_desc_i  (res_o.data.descending),
  .out_end_i   (res_o.data.end_of_run)
);

`default_nettype wire

>>> bench/sea_sort_checker.sv
// ----------------------------------------------------------------------------
// sea_sort_checker
// watches both channels of the sort engine, keeps its own copy of the set
// being loaded, sorts it on the closing request and compares every result
// in order against the predicted ascending and descending runs
// ----------------------------------------------------------------------------
module sea_sort_checker #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  sea_pkg::in_req_t    req_data_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  sea_pkg::out_req_t   res_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         req_count_o,
  output int unsigned         res_count_o,
  output int unsigned         set_count_o,
  output int unsigned         ovf_set_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sea_pkg::*;

  logic signed [DataW-1:0] set_words [MAX_ITEMS];
  int unsigned             set_len = 0;
  logic                    set_ovf = 1'b0;
  out_req_t                sorted_results_q [$];
  out_req_t                want;

  int unsigned fails = 0;
  int unsigned n_req = 0;
  int unsigned n_res = 0;
  int unsigned n_sets = 0;
  int unsigned n_ovf_sets = 0;

  assign fail_count_o    = fails;
  assign pending_o       = sorted_results_q.size();
  assign req_count_o     = n_req;
  assign res_count_o     = n_res;
  assign set_count_o     = n_sets;
  assign ovf_set_count_o = n_ovf_sets;

  task automatic report_mismatch(input string msg);
    if (fails < 30) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fails++;
  endtask

  // exchange sort of the loaded set, then queue both runs
  function automatic void sort_and_queue_set();
    logic signed [DataW-1:0] tmp;
    out_req_t                r;
    for (int unsigned i = 0; i < set_len; i++) begin
      for (int unsigned j = i + 1; j < set_len; j++) begin
        if (set_words[i] > set_words[j]) begin
          tmp          = set_words[i];
          set_words[i] = set_words[j];
          set_words[j] = tmp;
        end
      end
    end
    for (int unsigned k = 0; k < set_len; k++) begin
      r.sorted_value = set_words[k];
      r.descending   = 1'b0;
      r.end_of_run   = 1'b0;
      r.overflowed   = set_ovf;
      sorted_results_q.push_back(r);
    end
    for (int unsigned k = 0; k < set_len; k++) begin
      r.sorted_value = set_words[set_len - 1 - k];
      r.descending   = 1'b1;
      r.end_of_run   = (k + 1 == set_len);
      r.overflowed   = set_ovf;
      sorted_results_q.push_back(r);
    end
    n_sets++;
    if (set_ovf) begin
      n_ovf_sets++;
    end
    set_len = 0;
    set_ovf = 1'b0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        n_req++;
        if (set_len < MAX_ITEMS) begin
          set_words[set_len] = req_data_i.value;
          set_len++;
        end else begin
          set_ovf = 1'b1;
        end
        if (req_data_i.last) begin
          sort_and_queue_set();
        end
      end
      if (res_valid_i && res_ready_i) begin
        n_res++;
        if (sorted_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0d desc %0b end %0b ovf %0b",
            res_data_i.sorted_value, res_data_i.descending, res_data_i.end_of_run,
            res_data_i.overflowed));
        end else begin
          want = sorted_results_q.pop_front();
          if (res_data_i.sorted_value !== want.sorted_value) begin
            report_mismatch($sformatf("result %0d sorted_value %0d, predicted %0d", n_res,
              res_data_i.sorted_value, want.sorted_value));
          end
          if (res_data_i.descending !== want.descending) begin
            report_mismatch($sformatf("result %0d descending %b, predicted %b", n_res,
              res_data_i.descending, want.descending));
          end
          if (res_data_i.end_of_run !== want.end_of_run) begin
            report_mismatch($sformatf("result %0d end_of_run %b, predicted %b", n_res,
              res_data_i.end_of_run, want.end_of_run));
          end
          if (res_data_i.overflowed !== want.overflowed) begin
            report_mismatch($sformatf("result %0d overflowed %b, predicted %b", n_res,
              res_data_i.overflowed, want.overflowed));
          end
        end
      end
    end
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the sort engine: directed sets for the corner
// values, equal values and a full buffer, then random sets of mixed sizes
// under three idling regimes, checked by sea_sort_checker
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sea_pkg::*;

  localparam int unsigned MaxItems      = 16;
  localparam int unsigned QuietLimit    = 4000;
  localparam int unsigned ItemsPerPhase = 125;
  localparam int unsigned TailCycles    = 20;

  typedef enum int unsigned {
    ValWide,
    ValNarrow,
    ValCorner
  } val_mix_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  sea_stream_if #(.data_t(in_req_t))  req_if ();
  sea_stream_if #(.data_t(out_req_t)) res_if ();

  sort_engine_asc_desc #(
    .MAX_ITEMS(MaxItems)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  int unsigned chk_fails, chk_pending, chk_reqs, chk_results, chk_sets, chk_ovf_sets;

  sea_sort_checker #(
    .MAX_ITEMS(MaxItems)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_if.valid),
    .req_ready_i    (req_if.ready),
    .req_data_i     (req_if.data),
    .res_valid_i    (res_if.valid),
    .res_ready_i    (res_if.ready),
    .res_data_i     (res_if.data),
    .fail_count_o   (chk_fails),
    .pending_o      (chk_pending),
    .req_count_o    (chk_reqs),
    .res_count_o    (chk_results),
    .set_count_o    (chk_sets),
    .ovf_set_count_o(chk_ovf_sets)
  );

  int unsigned src_idle_pct  = 33;
  int unsigned sink_idle_pct = 51;
  int unsigned sent_items    = 0;
  int unsigned quiet_cycles  = 0;

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
        quiet_cycles, chk_pending);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [DataW-1:0] pick_value(input val_mix_e mix);
    case (mix)
      ValNarrow: return $signed($urandom_range(16)) - 8;
      ValCorner: begin
        case ($urandom_range(5))
          0:       return 32'sh8000_0000;
          1:       return 32'sh8000_0001;
          2:       return 32'sh7fff_ffff;
          3:       return 32'sh7fff_fffe;
          4:       return '0;
          default: return '1;
        endcase
      end
      default:   return $urandom;
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_req(input logic signed [DataW-1:0] v, input logic l);
    in_req_t d;
    d.value = v;
    d.last  = l;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= d;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_set(input int unsigned len, input val_mix_e mix);
    for (int unsigned i = 0; i < len; i++) begin
      send_req(pick_value(mix), i + 1 == len);
    end
  endtask

  int unsigned phase_start;
  int unsigned set_len;

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single element set
    send_req(32'sh7fff_ffff, 1'b1);
    // equal values and both extremes
    send_req(32'sd7, 1'b0);
    send_req(-32'sd3, 1'b0);
    send_req(32'sd7, 1'b0);
    send_req(32'sh8000_0000, 1'b0);
    send_req(32'sh7fff_ffff, 1'b0);
    send_req('0, 1'b0);
    send_req('1, 1'b0);
    send_req('1, 1'b1);
    // full buffer, closing request dropped
    send_set(MaxItems + 1, ValNarrow);

    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 33;
          sink_idle_pct = 51;
        end
        1: begin
          src_idle_pct  = 51;
          sink_idle_pct = 33;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      phase_start = sent_items;
      while (sent_items - phase_start < ItemsPerPhase) begin
        if ($urandom_range(99) < 15) begin
          set_len = $urandom_range(MaxItems + 6, MaxItems + 1);
        end else begin
          set_len = $urandom_range(MaxItems, 1);
        end
        send_set(set_len, val_mix_e'($urandom_range(2)));
      end
    end

    req_if.valid <= 1'b0;
    while (chk_pending != 0) begin
      @(negedge clk_i);
    end
    repeat (TailCycles) @(negedge clk_i);

    $display("covered %0d requests in %0d sets, %0d of them overflowed", chk_reqs, chk_sets,
      chk_ovf_sets);
    $display("checked %0d results, %0d mismatches", chk_results, chk_fails);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/sea_pkg.sv
hw/rtl/sea_stream_if.sv
hw/rtl/sea_out_reg.sv
hw/rtl/sea_sorter.sv
hw/rtl/sort_engine_asc_desc.sv
hw/rtl/sea_checker.sv
bench/sea_sort_checker.sv
bench/tb_top.sv
